// ===== sv/lkv_pkg.sv =====
`default_nettype none
package lkv_pkg;

  localparam int MODE_BITS  = 2;
  localparam int CAP_BITS   = 5;
  localparam int OCC_BITS   = 5;
  localparam int FIELD_BITS = 32;
  localparam int CNT_BITS   = 32;
  localparam int ADDR_BITS  = 3;
  localparam int DATA_BITS  = 32;

  localparam logic [MODE_BITS-1:0] MODE_LOOKUP = 2'd0;
  localparam logic [MODE_BITS-1:0] MODE_INSERT = 2'd1;
  localparam logic [MODE_BITS-1:0] MODE_CLEAR  = 2'd2;

  // register index as taken from the word address bit of paddr
  localparam logic REG_CAPACITY = 1'b0;

  localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MATCH,
    ST_SELECT,
    ST_READ,
    ST_COMMIT
  } state_t;

  typedef struct packed {
    logic capture;
    logic match;
    logic select;
    logic commit;
  } cmd_t;

endpackage
`default_nettype wire

// ===== sv/lkv_ctrl.sv =====
`default_nettype none
module lkv_ctrl
  import lkv_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  wire logic out_ready,
  output cmd_t      cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    in_ready      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_MATCH;
        end
      end
      ST_MATCH: begin
        cmd.match = 1'b1;
        state_nxt = ST_SELECT;
      end
      ST_SELECT: begin
        cmd.select = 1'b1;
        state_nxt  = ST_READ;
      end
      ST_READ: begin
        state_nxt = ST_COMMIT;
      end
      ST_COMMIT: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          cmd.commit    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;

`ifndef ASSERT_OFF
  a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (!out_valid_r || out_ready))
    else $error("commit while output word still pending");

  a_accept_match: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == ST_MATCH))
    else $error("accepted word did not start a match");

  a_rise_commit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cmd.commit))
    else $error("output word raised without commit");
`endif

endmodule
`default_nettype wire

// ===== sv/lkv_datapath.sv =====
`default_nettype none
module lkv_datapath
  import lkv_pkg::*;
#(
  parameter int ENTRIES    = 16,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
)(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire cmd_t                  cmd,
  input  wire logic [CAP_BITS-1:0]   capacity,
  input  wire logic [MODE_BITS-1:0]  in_mode,
  input  wire logic [FIELD_BITS-1:0] in_key,
  input  wire logic [FIELD_BITS-1:0] in_value,
  output logic                       out_hit,
  output logic [FIELD_BITS-1:0]      out_read_value,
  output logic                       out_evicted,
  output logic [OCC_BITS-1:0]        out_occupancy,
  output logic [CNT_BITS-1:0]        out_hit_total,
  output logic [CNT_BITS-1:0]        out_miss_total
);

  localparam int IW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int EW = CW + CAP_BITS;

  // valid entries always occupy slots 0 .. count-1
  logic [MODE_BITS-1:0]  mode_r;
  logic [KEY_BITS-1:0]   key_r;
  logic [VALUE_BITS-1:0] val_r;
  logic [KEY_BITS-1:0]   keys_r [ENTRIES];
  logic [IW-1:0]         ranks_r [ENTRIES];
  logic [VALUE_BITS-1:0] vmem [ENTRIES];
  logic [VALUE_BITS-1:0] rd_r;
  logic [CW-1:0]         count_r, count_nxt;
  logic [CNT_BITS-1:0]   hits_r, hits_nxt;
  logic [CNT_BITS-1:0]   misses_r, misses_nxt;
  logic [ENTRIES-1:0]    match_r, victim_r;
  logic                  hit_r;
  logic [IW-1:0]         hit_slot_r, hit_rank_r, victim_slot_r;
  logic [IW-1:0]         hit_slot_c, hit_rank_c, victim_slot_c;

  logic          is_lookup, is_insert, is_clear;
  logic          new_c, evict_c, touch_c;
  logic [IW-1:0] tslot, trank;
  logic [EW-1:0] cap_w, ent_w, eff_w;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r <= in_mode;
      key_r  <= KEY_BITS'(in_key);
      val_r  <= VALUE_BITS'(in_value);
    end
  end

  // compare every lane against the key, flag the oldest lane
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r  <= '0;
      victim_r <= '0;
    end else if (cmd.match) begin
      for (int i = 0; i < ENTRIES; i++) begin
        match_r[i]  <= (CW'(i) < count_r) && (keys_r[i] == key_r);
        victim_r[i] <= (CW'(i) < count_r) && (ranks_r[i] == IW'(count_r - CW'(1)));
      end
    end
  end

  // both vectors are one-hot or empty, so an OR reduction encodes them
  always_comb begin
    hit_slot_c    = '0;
    hit_rank_c    = '0;
    victim_slot_c = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (match_r[i]) begin
        hit_slot_c = hit_slot_c | IW'(i);
        hit_rank_c = hit_rank_c | ranks_r[i];
      end
      if (victim_r[i]) victim_slot_c = victim_slot_c | IW'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.select) begin
      hit_r         <= |match_r;
      hit_slot_r    <= hit_slot_c;
      hit_rank_r    <= hit_rank_c;
      victim_slot_r <= victim_slot_c;
    end
  end

  always_ff @(posedge clk) begin
    rd_r <= vmem[hit_slot_r];
    if (cmd.commit && is_insert) vmem[tslot] <= val_r;
  end

  always_comb begin
    is_lookup = (mode_r == MODE_LOOKUP);
    is_insert = (mode_r == MODE_INSERT);
    is_clear  = (mode_r == MODE_CLEAR);

    cap_w = EW'(capacity);
    ent_w = EW'(ENTRIES);
    if (cap_w == '0)        eff_w = EW'(1);
    else if (cap_w > ent_w) eff_w = ent_w;
    else                    eff_w = cap_w;

    new_c   = is_insert && !hit_r;
    evict_c = new_c && (EW'(count_r) >= eff_w);
    touch_c = (is_lookup && hit_r) || is_insert;

    if (hit_r) begin
      tslot = hit_slot_r;
      trank = hit_rank_r;
    end else if (evict_c) begin
      tslot = victim_slot_r;
      trank = IW'(count_r - CW'(1));
    end else begin
      tslot = count_r[IW-1:0];
      trank = count_r[IW-1:0];
    end

    count_nxt  = count_r;
    hits_nxt   = hits_r;
    misses_nxt = misses_r;
    if (is_clear) begin
      count_nxt  = '0;
      hits_nxt   = '0;
      misses_nxt = '0;
    end else if (new_c && !evict_c) begin
      count_nxt = count_r + CW'(1);
    end else if (is_lookup && hit_r) begin
      if (hits_r != '1) hits_nxt = hits_r + CNT_BITS'(1);
    end else if (is_lookup) begin
      if (misses_r != '1) misses_nxt = misses_r + CNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      hits_r   <= '0;
      misses_r <= '0;
    end else if (cmd.commit) begin
      count_r  <= count_nxt;
      hits_r   <= hits_nxt;
      misses_r <= misses_nxt;
    end
  end

  // age every live lane more recent than the touched one
  always_ff @(posedge clk) begin
    if (cmd.commit && touch_c) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (IW'(i) == tslot)
          ranks_r[i] <= '0;
        else if ((CW'(i) < count_r) && (ranks_r[i] < trank))
          ranks_r[i] <= ranks_r[i] + IW'(1);
      end
    end
    if (cmd.commit && new_c) keys_r[tslot] <= key_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_hit        <= hit_r && (is_lookup || is_insert);
      out_read_value <= (is_lookup && hit_r) ? FIELD_BITS'(rd_r) : '0;
      out_evicted    <= evict_c;
      out_occupancy  <= OCC_BITS'(count_nxt);
      out_hit_total  <= hits_nxt;
      out_miss_total <= misses_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_keys_unique: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(match_r))
    else $error("key present in more than one lane");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(ENTRIES))
    else $error("occupancy beyond store depth");
`endif

endmodule
`default_nettype wire

// ===== sv/lru_key_value_cache.sv =====
`default_nettype none
// Fully associative key-value cache with least-recently-used replacement.
// One item is handled at a time and passes these steps from acceptance to
// the result word: compare the key against every lane and flag the
// oldest lane, encode the matching slot, do the registered read
// of the value memory, and commit the update and load the output
// register; in_ready returns in the cycle after commit, so no new item is
// taken before the last one commits. The next item is
// taken while the result still waits on out_ready, but its commit holds
// until the output register is free. Capacity is set through the register
// at byte address 0 (0 acts as 1, values above ENTRIES act as ENTRIES);
// lowering it below occupancy makes each new insert evict exactly one entry.
module lru_key_value_cache
  import lkv_pkg::*;
#(
  parameter int ENTRIES    = 16,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
)(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [MODE_BITS-1:0]  in_mode,
  input  wire logic [FIELD_BITS-1:0] in_key,
  input  wire logic [FIELD_BITS-1:0] in_value,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic                       out_hit,
  output logic [FIELD_BITS-1:0]      out_read_value,
  output logic                       out_evicted,
  output logic [OCC_BITS-1:0]        out_occupancy,
  output logic [CNT_BITS-1:0]        out_hit_total,
  output logic [CNT_BITS-1:0]        out_miss_total,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [ADDR_BITS-1:0]  paddr,
  input  wire logic [DATA_BITS-1:0]  pwdata,
  output logic [DATA_BITS-1:0]       prdata,
  output logic                       pready
);

  cmd_t                cmd;
  logic [CAP_BITS-1:0] cap_r;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == REG_CAPACITY)) begin
      cap_r <= pwdata[CAP_BITS-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_CAPACITY) prdata = DATA_BITS'(cap_r);
  end

  lkv_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  lkv_datapath #(
    .ENTRIES    (ENTRIES),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .capacity       (cap_r),
    .in_mode        (in_mode),
    .in_key         (in_key),
    .in_value       (in_value),
    .out_hit        (out_hit),
    .out_read_value (out_read_value),
    .out_evicted    (out_evicted),
    .out_occupancy  (out_occupancy),
    .out_hit_total  (out_hit_total),
    .out_miss_total (out_miss_total)
  );

endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
module tb_top;
  import lkv_pkg::*;

  localparam int LINES          = 16;
  localparam int STALL_LIMIT    = 4000;
  localparam int DRAIN_CYCLES   = 10;
  localparam int KEY_POOL_SIZE  = 24;
  localparam logic [CNT_BITS-1:0] COUNT_MAX = '1;

  typedef struct packed {
    logic [MODE_BITS-1:0]  mode;
    logic [FIELD_BITS-1:0] key;
    logic [FIELD_BITS-1:0] value;
  } cache_op_t;

  typedef struct packed {
    logic                  hit;
    logic [FIELD_BITS-1:0] read_value;
    logic                  evicted;
    logic [OCC_BITS-1:0]   occupancy;
    logic [CNT_BITS-1:0]   hit_total;
    logic [CNT_BITS-1:0]   miss_total;
  } cache_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [MODE_BITS-1:0]  in_mode = '0;
  logic [FIELD_BITS-1:0] in_key = '0;
  logic [FIELD_BITS-1:0] in_value = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  out_hit;
  logic [FIELD_BITS-1:0] out_read_value;
  logic                  out_evicted;
  logic [OCC_BITS-1:0]   out_occupancy;
  logic [CNT_BITS-1:0]   out_hit_total;
  logic [CNT_BITS-1:0]   out_miss_total;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [ADDR_BITS-1:0]  paddr = '0;
  logic [DATA_BITS-1:0]  pwdata = '0;
  logic [DATA_BITS-1:0]  prdata;
  logic                  pready;

  cache_op_t     pending_ops[$];
  cache_result_t expected_results[$];
  cache_op_t     next_op;
  cache_result_t seen_result;
  cache_result_t want_result;

  // predictor's own copy of the store
  logic [FIELD_BITS-1:0] line_key[LINES];
  logic [FIELD_BITS-1:0] line_value[LINES];
  logic                  line_valid[LINES];
  int                    line_rank[LINES];
  int                    line_count;
  logic [CNT_BITS-1:0]   hit_count;
  logic [CNT_BITS-1:0]   miss_count;
  logic [CAP_BITS-1:0]   capacity_reg;

  logic [FIELD_BITS-1:0] key_pool[KEY_POOL_SIZE];
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int error_count = 0;
  int idle_cycles = 0;

  lru_key_value_cache u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_mode        (in_mode),
    .in_key         (in_key),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_hit        (out_hit),
    .out_read_value (out_read_value),
    .out_evicted    (out_evicted),
    .out_occupancy  (out_occupancy),
    .out_hit_total  (out_hit_total),
    .out_miss_total (out_miss_total),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always #5 clk = ~clk;

  function automatic void empty_store();
    for (int i = 0; i < LINES; i++) begin
      line_key[i]   = '0;
      line_value[i] = '0;
      line_valid[i] = 1'b0;
      line_rank[i]  = 0;
    end
    line_count = 0;
    hit_count  = '0;
    miss_count = '0;
  endfunction

  // make a line most recent; every more recent valid line ages by one
  function automatic void touch_line(int slot);
    int old_rank;
    old_rank = line_rank[slot];
    for (int i = 0; i < LINES; i++) begin
      if (line_valid[i] && i != slot && line_rank[i] < old_rank) line_rank[i]++;
    end
    line_rank[slot] = 0;
  endfunction

  function automatic cache_result_t apply_cache_op(logic [MODE_BITS-1:0] mode,
                                                   logic [FIELD_BITS-1:0] key,
                                                   logic [FIELD_BITS-1:0] value);
    cache_result_t res;
    int slot;
    int victim;
    int eff_cap;
    res = '0;
    slot = -1;
    for (int i = 0; i < LINES; i++) begin
      if (slot < 0 && line_valid[i] && line_key[i] == key) slot = i;
    end
    case (mode)
      MODE_LOOKUP: begin
        if (slot >= 0) begin
          res.hit = 1'b1;
          res.read_value = line_value[slot];
          touch_line(slot);
          if (hit_count != COUNT_MAX) hit_count++;
        end else if (miss_count != COUNT_MAX) begin
          miss_count++;
        end
      end
      MODE_INSERT: begin
        if (slot >= 0) begin
          res.hit = 1'b1;
          line_value[slot] = value;
          touch_line(slot);
        end else begin
          eff_cap = (capacity_reg == 0) ? 1 : ((capacity_reg > LINES) ? LINES : capacity_reg);
          if (line_count >= eff_cap && line_count > 0) begin
            victim = -1;
            for (int i = 0; i < LINES; i++) begin
              if (line_valid[i] && (victim < 0 || line_rank[i] > line_rank[victim])) victim = i;
            end
            if (victim >= 0) begin
              line_valid[victim] = 1'b0;
              line_count--;
              res.evicted = 1'b1;
            end
          end
          for (int i = 0; i < LINES; i++) begin
            if (slot < 0 && !line_valid[i]) slot = i;
          end
          if (slot >= 0) begin
            for (int i = 0; i < LINES; i++) begin
              if (line_valid[i]) line_rank[i]++;
            end
            line_key[slot]   = key;
            line_value[slot] = value;
            line_valid[slot] = 1'b1;
            line_rank[slot]  = 0;
            line_count++;
          end
        end
      end
      MODE_CLEAR: begin
        empty_store();
      end
      default: begin
      end
    endcase
    res.occupancy  = line_count[OCC_BITS-1:0];
    res.hit_total  = hit_count;
    res.miss_total = miss_count;
    return res;
  endfunction

  function automatic void queue_op(logic [MODE_BITS-1:0] mode, logic [FIELD_BITS-1:0] key,
                                   logic [FIELD_BITS-1:0] value);
    cache_op_t op;
    op.mode  = mode;
    op.key   = key;
    op.value = value;
    pending_ops.insert(pending_ops.size(), op);
  endfunction

  function automatic void queue_random_op();
    int pick;
    logic [MODE_BITS-1:0] mode;
    logic [FIELD_BITS-1:0] key;
    pick = $urandom_range(99);
    if (pick < 46) mode = MODE_LOOKUP;
    else if (pick < 92) mode = MODE_INSERT;
    else if (pick < 95) mode = MODE_CLEAR;
    else mode = ~MODE_LOOKUP;
    // mostly reuse a small key set so that hits and evictions are common
    if ($urandom_range(99) < 80) key = key_pool[$urandom_range(KEY_POOL_SIZE - 1)];
    else key = $urandom;
    queue_op(mode, key, $urandom);
  endfunction

  // driver: hold the word until taken, then fetch the next one
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (pending_ops.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        next_op = pending_ops.pop_front();
        in_valid <= 1'b1;
        in_mode  <= next_op.mode;
        in_key   <= next_op.key;
        in_value <= next_op.value;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // monitor: check the result word first, then predict the word taken in
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      seen_result.hit        = out_hit;
      seen_result.read_value = out_read_value;
      seen_result.evicted    = out_evicted;
      seen_result.occupancy  = out_occupancy;
      seen_result.hit_total  = out_hit_total;
      seen_result.miss_total = out_miss_total;
      if (expected_results.size() == 0) begin
        $error("result word with nothing expected");
        error_count++;
      end else begin
        want_result = expected_results.pop_front();
        if (seen_result.hit !== want_result.hit) begin
          $error("hit: expected %0d, got %0d", want_result.hit, seen_result.hit);
          error_count++;
        end
        if (seen_result.read_value !== want_result.read_value) begin
          $error("read_value: expected %0h, got %0h", want_result.read_value,
                 seen_result.read_value);
          error_count++;
        end
        if (seen_result.evicted !== want_result.evicted) begin
          $error("evicted: expected %0d, got %0d", want_result.evicted, seen_result.evicted);
          error_count++;
        end
        if (seen_result.occupancy !== want_result.occupancy) begin
          $error("occupancy: expected %0d, got %0d", want_result.occupancy,
                 seen_result.occupancy);
          error_count++;
        end
        if (seen_result.hit_total !== want_result.hit_total) begin
          $error("hit_total: expected %0d, got %0d", want_result.hit_total,
                 seen_result.hit_total);
          error_count++;
        end
        if (seen_result.miss_total !== want_result.miss_total) begin
          $error("miss_total: expected %0d, got %0d", want_result.miss_total,
                 seen_result.miss_total);
          error_count++;
        end
      end
    end
    if (rst_n && in_valid && in_ready) begin
      expected_results.insert(expected_results.size(),
                              apply_cache_op(in_mode, in_key, in_value));
    end
  end

  // watchdog: count cycles in which no word moves on any port
  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else if ((in_valid && in_ready) || (out_valid && out_ready) ||
                 (psel && penable && pwrite && pready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic wait_idle();
    while (pending_ops.size() != 0 || in_valid || expected_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (5) @(posedge clk);
  endtask

  task automatic write_capacity(logic [CAP_BITS-1:0] cap);
    wait_idle();
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_CAPACITY, 2'b00};
    pwdata  <= DATA_BITS'(cap);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    capacity_reg = cap;
  endtask

  int phase_caps[12] = '{16, 3, 31, 1, 9, 0, 16, 4, 2, 24, 12, 16};
  int phase_send[4]  = '{0, 57, 0, 13};
  int phase_recv[4]  = '{0, 0, 57, 13};

  initial begin
    empty_store();
    capacity_reg = CAP_RESET;
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < KEY_POOL_SIZE; i++) key_pool[i] = $urandom;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // extremes, unused mode, update, clear, lookups on an empty store
    queue_op(~MODE_LOOKUP, '1, '1);
    queue_op(MODE_LOOKUP, '0, '1);
    queue_op(MODE_INSERT, '0, '0);
    queue_op(MODE_INSERT, '1, '1);
    queue_op(MODE_LOOKUP, '1, '0);
    queue_op(MODE_LOOKUP, '0, '0);
    queue_op(MODE_INSERT, '0, 32'ha5a5_a5a5);
    queue_op(MODE_LOOKUP, '0, '0);
    queue_op(MODE_LOOKUP, 32'h1234_5678, '0);
    queue_op(~MODE_LOOKUP, '0, '0);
    queue_op(MODE_CLEAR, '1, '1);
    queue_op(MODE_LOOKUP, '1, '0);

    // zero capacity acts as one entry
    write_capacity('0);
    queue_op(MODE_INSERT, 32'd1, 32'd11);
    queue_op(MODE_INSERT, 32'd2, 32'd22);
    queue_op(MODE_LOOKUP, 32'd1, '0);
    queue_op(MODE_LOOKUP, 32'd2, '0);

    // lookup refreshes an entry, so the other one is the victim
    write_capacity(5'd2);
    queue_op(MODE_INSERT, 32'd3, 32'd33);
    queue_op(MODE_LOOKUP, 32'd2, '0);
    queue_op(MODE_INSERT, 32'd4, 32'd44);
    queue_op(MODE_LOOKUP, 32'd3, '0);
    queue_op(MODE_LOOKUP, 32'd2, '0);

    // random phases; capacity drops below occupancy between some of them
    for (int p = 0; p < 12; p++) begin
      write_capacity(phase_caps[p][CAP_BITS-1:0]);
      send_idle_pct  = phase_send[p % 4];
      recv_stall_pct = phase_recv[p % 4];
      for (int n = 0; n < 104; n++) queue_random_op();
    end

    while (pending_ops.size() != 0 || in_valid || expected_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/lkv_pkg.sv
sv/lkv_ctrl.sv
sv/lkv_datapath.sv
sv/lru_key_value_cache.sv
verif/tb_top.sv
